[rtl/xbr_pkg.sv]
// Shared types, constants and helper functions for the XMODEM-CRC block receiver.
// No dependencies; every other RTL file imports this package.
package xbr_pkg;

  // Transaction payloads
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [27:0] data_offset;
    logic [2:0]  block_verdict;
    logic [2:0]  status;
    logic        last;
  } out_t;

  // Up to two results per input, handed from core to output queue
  typedef struct packed {
    logic [1:0] count;
    out_t       res0;
    out_t       res1;
  } res_pair_t;

  // Fixed widths
  localparam int unsigned LEN_W   = 29;
  localparam int unsigned OFF_W   = 28;
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned TRIES_W = 7;

  localparam logic [TRIES_W-1:0] START_TRIES_DEF = 7'd100;

  // Block sizes
  localparam logic [IDX_W-1:0] SZ_SMALL = 11'd128;
  localparam logic [IDX_W-1:0] SZ_BIG   = 11'd1024;

  // Opcodes
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_BYTE    = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // Line characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_C   = 8'h43;

  // Block verdicts
  localparam logic [2:0] VD_NONE  = 3'd0;
  localparam logic [2:0] VD_OK    = 3'd1;
  localparam logic [2:0] VD_DUP   = 3'd2;
  localparam logic [2:0] VD_BAD   = 3'd3;
  localparam logic [2:0] VD_SEQ   = 3'd4;

  // Transfer status
  localparam logic [2:0] ST_BUSY     = 3'd0;
  localparam logic [2:0] ST_DONE     = 3'd1;
  localparam logic [2:0] ST_CAN_US   = 3'd2;
  localparam logic [2:0] ST_CAN_PEER = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;

  // Receiver phases, one-hot
  typedef enum logic [7:0] {
    PH_IDLE  = 8'b0000_0001,
    PH_START = 8'b0000_0010,
    PH_NUM   = 8'b0000_0100,
    PH_INV   = 8'b0000_1000,
    PH_DATA  = 8'b0001_0000,
    PH_CRCH  = 8'b0010_0000,
    PH_CRCL  = 8'b0100_0000,
    PH_MARK  = 8'b1000_0000
  } phase_t;

  // CRC-16/XMODEM, one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ 16'h1021;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Control byte result, no payload
  function automatic out_t mk_tx(input logic [7:0] b, input logic [2:0] verdict,
                                 input logic [2:0] status, input logic last);
    out_t r;
    r               = '0;
    r.tx_valid      = 1'b1;
    r.tx_byte       = b;
    r.block_verdict = verdict;
    r.status        = status;
    r.last          = last;
    return r;
  endfunction

endpackage

[rtl/xbr_core.sv]
// Protocol state and per-byte decode of the receiver: one transaction per cycle while in_take is high.
// Depends on xbr_pkg (types, characters, CRC function).
module xbr_core
  import xbr_pkg::*;
#(
  parameter logic [TRIES_W-1:0] START_TRIES = START_TRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_len,
  input  logic             in_take,
  input  in_t              in_item,
  output res_pair_t        res
);

  phase_t               phase_r, phase_nxt;
  logic [TRIES_W-1:0]   tries_r, tries_nxt;
  logic                 big_r, big_nxt;
  logic [7:0]           exp_blk_r, exp_blk_nxt;
  logic [7:0]           got_num_r, got_num_nxt;
  logic [7:0]           got_inv_r, got_inv_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [15:0]          crc_r, crc_nxt;
  logic [7:0]           crc_hi_r, crc_hi_nxt;
  logic [LEN_W-1:0]     written_r, written_nxt;
  logic [LEN_W-1:0]     total_r;

  logic [IDX_W-1:0]     blk_size;
  logic [LEN_W:0]       offset;
  logic [LEN_W-1:0]     remain;
  logic [LEN_W-1:0]     grow;
  logic [IDX_W-1:0]     idx_inc;
  logic                 is_marker;
  out_t                 can0, can1;

  assign blk_size  = big_r ? SZ_BIG : SZ_SMALL;
  assign offset    = {1'b0, written_r} + {{(LEN_W+1-IDX_W){1'b0}}, idx_r};
  assign remain    = total_r - written_r;
  assign grow      = (remain > {{(LEN_W-IDX_W){1'b0}}, blk_size}) ?
                     {{(LEN_W-IDX_W){1'b0}}, blk_size} : remain;
  assign idx_inc   = idx_r + 1'b1;
  assign is_marker = (in_item.rx_byte == CH_SOH) || (in_item.rx_byte == CH_STX);

  // Next state and results
  always_comb begin
    phase_nxt   = phase_r;
    tries_nxt   = tries_r;
    big_nxt     = big_r;
    exp_blk_nxt = exp_blk_r;
    got_num_nxt = got_num_r;
    got_inv_nxt = got_inv_r;
    idx_nxt     = idx_r;
    crc_nxt     = crc_r;
    crc_hi_nxt  = crc_hi_r;
    written_nxt = written_r;
    res         = '0;
    can0        = mk_tx(CH_CAN, VD_NONE, ST_CAN_US, 1'b0);
    can1        = mk_tx(CH_CAN, VD_NONE, ST_CAN_US, 1'b1);

    if (in_take) begin
      if (in_item.opcode == OP_START) begin
        exp_blk_nxt = 8'd1;
        written_nxt = '0;
        tries_nxt   = 7'd1;
        big_nxt     = 1'b0;
        idx_nxt     = '0;
        crc_nxt     = '0;
        crc_hi_nxt  = '0;
        got_num_nxt = '0;
        got_inv_nxt = '0;
        phase_nxt   = PH_START;
        res.count   = 2'd1;
        res.res0    = mk_tx(CH_C, VD_NONE, ST_BUSY, 1'b1);
      end else if (phase_r != PH_IDLE && in_item.opcode == OP_TIMEOUT) begin
        if (phase_r == PH_START) begin
          if (tries_r < START_TRIES) begin
            tries_nxt = tries_r + 1'b1;
            res.count = 2'd1;
            res.res0  = mk_tx(CH_C, VD_NONE, ST_BUSY, 1'b1);
          end else begin
            phase_nxt = PH_IDLE;
            res.count = 2'd2;
            res.res0  = can0;
            res.res1  = can1;
          end
        end else begin
          // Timeout mid-transfer: report only
          phase_nxt = PH_IDLE;
          res.count = 2'd1;
          res.res0  = '0;
          res.res0.status = ST_TIMEOUT;
          res.res0.last   = 1'b1;
        end
      end else if (phase_r != PH_IDLE && in_item.opcode == OP_BYTE) begin
        case (phase_r)
          PH_START, PH_MARK: begin
            if (is_marker) begin
              big_nxt     = (in_item.rx_byte == CH_STX);
              got_num_nxt = '0;
              got_inv_nxt = '0;
              idx_nxt     = '0;
              crc_nxt     = '0;
              crc_hi_nxt  = '0;
              phase_nxt   = PH_NUM;
            end else if (phase_r == PH_START) begin
              phase_nxt = PH_IDLE;
              res.count = 2'd2;
              res.res0  = can0;
              res.res1  = can1;
            end else if (in_item.rx_byte == CH_EOT) begin
              phase_nxt = PH_IDLE;
              if (written_r == total_r) begin
                res.count = 2'd1;
                res.res0  = mk_tx(CH_ACK, VD_NONE, ST_DONE, 1'b1);
              end else begin
                res.count = 2'd2;
                res.res0  = can0;
                res.res1  = can1;
              end
            end else if (in_item.rx_byte == CH_CAN) begin
              phase_nxt = PH_IDLE;
              res.count = 2'd1;
              res.res0  = '0;
              res.res0.status = ST_CAN_PEER;
              res.res0.last   = 1'b1;
            end else begin
              res.count = 2'd1;
              res.res0  = mk_tx(CH_NAK, VD_NONE, ST_BUSY, 1'b1);
            end
          end
          PH_NUM: begin
            got_num_nxt = in_item.rx_byte;
            phase_nxt   = PH_INV;
          end
          PH_INV: begin
            got_inv_nxt = in_item.rx_byte;
            phase_nxt   = PH_DATA;
          end
          PH_DATA: begin
            crc_nxt = crc_byte(crc_r, in_item.rx_byte);
            if (offset < {1'b0, total_r}) begin
              res.count = 2'd1;
              res.res0  = '0;
              res.res0.data_valid  = 1'b1;
              res.res0.data_byte   = in_item.rx_byte;
              res.res0.data_offset = offset[OFF_W-1:0];
              res.res0.last        = 1'b1;
            end
            idx_nxt = idx_inc;
            if (idx_inc >= blk_size) begin
              phase_nxt = PH_CRCH;
            end
          end
          PH_CRCH: begin
            crc_hi_nxt = in_item.rx_byte;
            phase_nxt  = PH_CRCL;
          end
          PH_CRCL: begin
            // Block end: integrity, then sequence
            phase_nxt = PH_MARK;
            if (got_inv_r != ~got_num_r || {crc_hi_r, in_item.rx_byte} != crc_r) begin
              res.count = 2'd1;
              res.res0  = mk_tx(CH_NAK, VD_BAD, ST_BUSY, 1'b1);
            end else if (got_num_r == exp_blk_r - 8'd1) begin
              res.count = 2'd1;
              res.res0  = mk_tx(CH_ACK, VD_DUP, ST_BUSY, 1'b1);
            end else if (got_num_r != exp_blk_r || written_r >= total_r) begin
              phase_nxt = PH_IDLE;
              res.count = 2'd2;
              res.res0  = mk_tx(CH_CAN, VD_SEQ, ST_CAN_US, 1'b0);
              res.res1  = mk_tx(CH_CAN, VD_SEQ, ST_CAN_US, 1'b1);
            end else begin
              written_nxt = written_r + grow;
              exp_blk_nxt = exp_blk_r + 8'd1;
              res.count   = 2'd1;
              res.res0    = mk_tx(CH_ACK, VD_OK, ST_BUSY, 1'b1);
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      tries_r   <= '0;
      big_r     <= 1'b0;
      exp_blk_r <= 8'd1;
      got_num_r <= '0;
      got_inv_r <= '0;
      idx_r     <= '0;
      crc_r     <= '0;
      crc_hi_r  <= '0;
      written_r <= '0;
      total_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      tries_r   <= tries_nxt;
      big_r     <= big_nxt;
      exp_blk_r <= exp_blk_nxt;
      got_num_r <= got_num_nxt;
      got_inv_r <= got_inv_nxt;
      idx_r     <= idx_nxt;
      crc_r     <= crc_nxt;
      crc_hi_r  <= crc_hi_nxt;
      written_r <= written_nxt;
      if (cfg_we) begin
        total_r <= cfg_len;
      end
    end
  end

endmodule

[rtl/xbr_outq.sv]
// Four-entry result queue: takes up to two results per cycle, hands out one.
// Depends on xbr_pkg (out_t, res_pair_t).
module xbr_outq
  import xbr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  res_pair_t push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_t      out_data
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  out_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             pop;
  logic [PTR_W-1:0] wr_ptr_1;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_data  = mem[rd_ptr_r];
  // Space for a worst-case pair regardless of the consumer
  assign room      = (count_r <= (PTR_W+1)'(DEPTH - 2));
  assign wr_ptr_1  = wr_ptr_r + 1'b1;
  assign count_nxt = count_r + {{(PTR_W-1){1'b0}}, push.count} - {{PTR_W{1'b0}}, pop};

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + push.count[PTR_W-1:0];
      rd_ptr_r <= rd_ptr_r + {{(PTR_W-1){1'b0}}, pop};
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr_r] <= push.res0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_1] <= push.res1;
    end
  end

endmodule

[rtl/xmodem_block_receiver.sv]
// XMODEM-CRC (128/1K) block receiver, top level. Depends on xbr_pkg, xbr_core, xbr_outq.
// A result is registered into the result queue and offered on out_ behind any older results.
// Throughput: one input per cycle while in_ready is high; a CAN CAN answer is two results,
// and input stalls only while the four-entry result queue holds more than two results.
// Reset (rst_n low, synchronous): phase idle, counters and total_length cleared, queue empty.
module xmodem_block_receiver
  import xbr_pkg::*;
#(
  parameter logic [TRIES_W-1:0] START_TRIES = START_TRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data
);

  res_pair_t res;
  logic      room;

  assign cfg_ready = 1'b1;
  assign in_ready  = room;

  xbr_core #(
    .START_TRIES(START_TRIES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_len (cfg_data),
    .in_take (in_valid && in_ready),
    .in_item (in_data),
    .res     (res)
  );

  xbr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/xbr_checker.sv]
// Port-level checks for the block receiver, bound to the top level.
// Depends on xbr_pkg and xmodem_block_receiver.
module xbr_checker
  import xbr_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // Queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("result offered straight after reset");

  // Stalled transaction holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // A result never carries both a control byte and a payload byte
  a_tx_xor_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.tx_valid && out_data.data_valid))
    else $error("control and payload in one result");

  // Payload fields are zero without a payload byte
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.data_valid |->
      out_data.data_byte == 8'h00 && out_data.data_offset == '0)
    else $error("payload fields set without data_valid");

endmodule

bind xmodem_block_receiver xbr_checker u_xbr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
